// ===== sv/stt_pkg.sv =====
// Shared constants, token kind codes and keyword table for the source text tokenizer.
package stt_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int QUEUE_DEPTH       = 4;

  localparam int KIND_BITS  = 4;
  localparam int CHAR_BITS  = 8;
  localparam int NAME_CHARS = 7;
  localparam int KW_COUNT   = 8;

  localparam logic [3:0] KIND_CHAR    = 4'd0;
  localparam logic [3:0] KIND_LITERAL = 4'd1;
  localparam logic [3:0] KIND_NAME    = 4'd2;
  localparam logic [3:0] KIND_LET     = 4'd3;
  localparam logic [3:0] KIND_SET     = 4'd4;
  localparam logic [3:0] KIND_WHILE   = 4'd5;
  localparam logic [3:0] KIND_IF      = 4'd6;
  localparam logic [3:0] KIND_ELIF    = 4'd7;
  localparam logic [3:0] KIND_ELSE    = 4'd8;
  localparam logic [3:0] KIND_FUNC    = 4'd9;
  localparam logic [3:0] KIND_RETURN  = 4'd10;
  localparam logic [3:0] KIND_GE      = 4'd11;
  localparam logic [3:0] KIND_LE      = 4'd12;
  localparam logic [3:0] KIND_EQ      = 4'd13;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  // first character in the low byte
  localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
    56'h0000000074656c,   // let
    56'h00000000746573,   // set
    56'h0000656c696877,   // while
    56'h00000000006669,   // if
    56'h00000066696c65,   // elif
    56'h00000065736c65,   // else
    56'h000000636e7566,   // func
    56'h006e7275746572    // return
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd3, 3'd5, 3'd2, 3'd4, 3'd4, 3'd4, 3'd6
  };
  localparam logic [3:0] KW_KIND [KW_COUNT] = '{
    KIND_LET, KIND_SET, KIND_WHILE, KIND_IF, KIND_ELIF, KIND_ELSE, KIND_FUNC, KIND_RETURN
  };

  function automatic logic [3:0] name_kind(input logic [55:0] prefix, input logic [2:0] len);
    logic [3:0] kind;
    kind = KIND_NAME;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

// ===== sv/stt_text_if.sv =====
// Source byte channel: valid/ready handshake carrying one text byte per request.
interface stt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       restart;

  modport source (output valid, output ch, output restart, input ready);
  modport sink   (input valid, input ch, input restart, output ready);
endinterface

// ===== sv/stt_token_if.sv =====
// Token channel: valid/ready handshake carrying one token record per request.
interface stt_token_if #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = stt_pkg::VALUE_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [7:0]               char_code;
  logic [VALUE_BITS-1:0]    literal_value;
  logic [POSITION_BITS-1:0] line_number;
  logic [POSITION_BITS-1:0] start_offset;
  logic [POSITION_BITS-1:0] end_offset;
  logic                     last;

  modport source (output valid, output token_kind, output char_code, output literal_value,
                  output line_number, output start_offset, output end_offset, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input char_code, input literal_value,
                  input line_number, input start_offset, input end_offset, input last,
                  output ready);
endinterface

// ===== sv/stt_front.sv =====
// Scanner front end: accepts bytes, tracks the pending token and emits up to two records.
module stt_front #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = stt_pkg::VALUE_BITS_DEF,
  parameter int REC_BITS      = 4 + 8 + VALUE_BITS + 3 * POSITION_BITS + 1
) (
  input  logic                clk,
  input  logic                rst,
  stt_text_if.sink            text,
  input  logic                space,
  output logic [1:0]          push_count,
  output logic [REC_BITS-1:0] rec0,
  output logic [REC_BITS-1:0] rec1
);
  import stt_pkg::*;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_NUM  = 6'b000010,
    MODE_NAME = 6'b000100,
    MODE_GT   = 6'b001000,
    MODE_LT   = 6'b010000,
    MODE_EQ   = 6'b100000
  } scan_mode_t;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  scan_mode_t               mode, mode_next, mode_e;
  logic [VALUE_BITS-1:0]    acc, acc_next;
  logic [55:0]              prefix, prefix_next;
  logic [2:0]               len, len_next;
  logic [POSITION_BITS-1:0] line, line_next, line_e;
  logic [POSITION_BITS-1:0] offset, off_e;
  logic [POSITION_BITS-1:0] tstart, tstart_next;
  logic [POSITION_BITS-1:0] tline, tline_next;

  logic       accept, used, is_dig, is_alp, is_word;
  logic       a_en, b_en;
  logic [3:0] a_kind;
  logic [7:0] a_code;
  logic [VALUE_BITS-1:0]    a_val;
  logic [POSITION_BITS-1:0] a_end;

  function automatic logic [REC_BITS-1:0] pack(
    input logic [3:0] kind, input logic [7:0] code, input logic [VALUE_BITS-1:0] val,
    input logic [POSITION_BITS-1:0] ln, input logic [POSITION_BITS-1:0] st,
    input logic [POSITION_BITS-1:0] en, input logic lst);
    return {kind, code, val, ln, st, en, lst};
  endfunction

  assign text.ready = space;
  assign accept     = text.valid && space;

  always_comb begin
    mode_e  = text.restart ? MODE_IDLE : mode;
    line_e  = text.restart ? '0 : line;
    off_e   = text.restart ? '0 : offset;
    is_dig  = text.ch >= CH_ZERO && text.ch <= CH_NINE;
    is_alp  = (text.ch >= CH_LC_A && text.ch <= CH_LC_Z) ||
              (text.ch >= CH_UC_A && text.ch <= CH_UC_Z);
    is_word = is_alp || is_dig || text.ch == CH_UNDER;

    used        = 1'b0;
    a_en        = 1'b0;
    a_kind      = KIND_CHAR;
    a_code      = '0;
    a_val       = '0;
    a_end       = off_e;
    b_en        = 1'b0;
    acc_next    = acc;
    prefix_next = prefix;
    len_next    = len;
    line_next   = line_e;
    tstart_next = tstart;
    tline_next  = tline;

    case (mode_e)
      MODE_NUM: begin
        if (is_dig) begin
          acc_next = {acc[VALUE_BITS-4:0], 3'b000} + {acc[VALUE_BITS-2:0], 1'b0} +
                     VALUE_BITS'(text.ch[3:0]);
          used = 1'b1;
        end else begin
          a_en   = 1'b1;
          a_kind = KIND_LITERAL;
          a_val  = acc;
        end
      end
      MODE_NAME: begin
        if (is_word) begin
          if (len != 3'(NAME_CHARS)) begin
            for (int i = 0; i < NAME_CHARS; i++) begin
              if (len == 3'(i)) begin
                prefix_next[8*i +: 8] = text.ch;
              end
            end
            len_next = len + 3'd1;
          end
          used = 1'b1;
        end else begin
          a_en   = 1'b1;
          a_kind = name_kind(prefix, len);
        end
      end
      MODE_GT, MODE_LT, MODE_EQ: begin
        a_en = 1'b1;
        if (text.ch == CH_EQ) begin
          a_kind = (mode_e == MODE_GT) ? KIND_GE : (mode_e == MODE_LT) ? KIND_LE : KIND_EQ;
          a_end  = off_e + POS_ONE;
          used   = 1'b1;
        end else begin
          a_code = (mode_e == MODE_GT) ? CH_GT : (mode_e == MODE_LT) ? CH_LT : CH_EQ;
        end
      end
      default: ;
    endcase

    mode_next = (mode_e != MODE_IDLE && (!used || a_en)) ? MODE_IDLE : mode_e;

    if (!used) begin
      if (is_dig) begin
        mode_next   = MODE_NUM;
        tstart_next = off_e;
        tline_next  = line_e;
        acc_next    = VALUE_BITS'(text.ch[3:0]);
      end else if (is_alp || text.ch == CH_UNDER) begin
        mode_next   = MODE_NAME;
        tstart_next = off_e;
        tline_next  = line_e;
        prefix_next = 56'(text.ch);
        len_next    = 3'd1;
      end else if (text.ch == CH_SPACE || text.ch == CH_TAB) begin
        mode_next = mode_next;
      end else if (text.ch == CH_LF) begin
        line_next = line_e + POS_ONE;
      end else if (text.ch == CH_GT || text.ch == CH_LT || text.ch == CH_EQ) begin
        mode_next   = (text.ch == CH_GT) ? MODE_GT : (text.ch == CH_LT) ? MODE_LT : MODE_EQ;
        tstart_next = off_e;
        tline_next  = line_e;
      end else begin
        b_en = 1'b1;
      end
    end

    push_count = accept ? (2'(a_en) + 2'(b_en)) : 2'd0;
    rec1 = pack(KIND_CHAR, text.ch, '0, line_e, off_e, off_e + POS_ONE, 1'b1);
    rec0 = a_en ? pack(a_kind, a_code, a_val, tline, tstart, a_end, !b_en) : rec1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      line   <= '0;
      offset <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      line   <= line_next;
      offset <= off_e + POS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc    <= acc_next;
      prefix <= prefix_next;
      len    <= len_next;
      tstart <= tstart_next;
      tline  <= tline_next;
    end
  end

endmodule

// ===== sv/stt_queue.sv =====
// Token record queue between scanner and output stage: two writes, one read per cycle.
module stt_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  logic [DATA_BITS-1:0] rec0,
  input  logic [DATA_BITS-1:0] rec1,
  output logic                 space,
  input  logic                 pop,
  output logic                 q_valid,
  output logic [DATA_BITS-1:0] q_data
);
  import stt_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  logic [DATA_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr, wr_ptr_inc;
  logic [PTR_BITS:0]    count, count_next;

  assign wr_ptr_inc = wr_ptr + PTR_BITS'(1);
  assign space      = count <= (PTR_BITS + 1)'(QUEUE_DEPTH - 2);
  assign q_valid    = count != '0;
  assign q_data     = mem[rd_ptr];
  assign count_next = count + (PTR_BITS + 1)'(push_count) - (PTR_BITS + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= rec0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_inc] <= rec1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_BITS + 1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_push_needs_space: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> space) else $error("push without space");
  a_push_width: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd3) else $error("more than two records in one request");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("pop from empty queue");

endmodule

// ===== sv/stt_back.sv =====
// Output stage: registers one token record at a time and drives the token channel.
module stt_back #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = stt_pkg::VALUE_BITS_DEF,
  parameter int REC_BITS      = 4 + 8 + VALUE_BITS + 3 * POSITION_BITS + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  logic [REC_BITS-1:0] q_data,
  output logic                pop,
  stt_token_if.source         tokens
);
  logic                valid;
  logic [REC_BITS-1:0] data;

  assign pop = q_valid && (!valid || tokens.ready);
  assign tokens.valid = valid;
  assign {tokens.token_kind, tokens.char_code, tokens.literal_value, tokens.line_number,
          tokens.start_offset, tokens.end_offset, tokens.last} = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (tokens.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data <= q_data;
    end
  end

endmodule

// ===== sv/source_text_tokenizer.sv =====
// Source text tokenizer top level: scanner, record queue and output register.
//
// Usage: source bytes arrive on the text channel, one per request, with
// restart set on the first byte of a new text; a zero byte ends the text and
// comes out as a single-character token. Tokens leave on the tokens channel,
// one per request; last marks the final token caused by a given byte.
// Path: a token caused by an accepted byte is written into the queue and
// then into the output register, from which it is offered.
// Throughput: one byte per cycle while the queue has room; the output register
// moves one token per cycle while ready is high, and the four-entry queue
// absorbs the two tokens from a byte that closes a pending token and yields its own.
// The text channel is ready while the queue has room for two records.
// Stalls: when the receiver holds ready low the token stays registered, the
// queue fills and the text channel then drops ready; no token is lost.
// Reset clears the scanner mode, line and offset counters, the queue and the
// output register; the block takes bytes in the first cycle after reset.
module source_text_tokenizer #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = stt_pkg::VALUE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  stt_text_if.sink    text,
  stt_token_if.source tokens
);
  localparam int REC_BITS = 4 + 8 + VALUE_BITS + 3 * POSITION_BITS + 1;

  logic [1:0]          push_count;
  logic [REC_BITS-1:0] rec0, rec1, q_data;
  logic                space, pop, q_valid;

  stt_front #(
    .POSITION_BITS(POSITION_BITS),
    .VALUE_BITS   (VALUE_BITS),
    .REC_BITS     (REC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .space     (space),
    .push_count(push_count),
    .rec0      (rec0),
    .rec1      (rec1)
  );

  stt_queue #(
    .DATA_BITS(REC_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .rec0      (rec0),
    .rec1      (rec1),
    .space     (space),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  stt_back #(
    .POSITION_BITS(POSITION_BITS),
    .VALUE_BITS   (VALUE_BITS),
    .REC_BITS     (REC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_data (q_data),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule
